// ===== design/sfov_pkg.sv =====
// ----------------------------------------------------------------------------
// Shadowcast field of view package
// Shared types, codes and the octant transform table for the view block.
// ----------------------------------------------------------------------------
package sfov_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;
  localparam int MAX_RADIUS_DEF  = 63;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       opaque;
    logic [5:0] sight_radius;
  } in_item_t;

  typedef struct packed {
    logic [1:0] ack_opcode;
    logic       cell_visible;
    logic       cell_seen;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_VCLR,
    ST_ORIGIN,
    ST_OCT_INIT,
    ST_ROW,
    ST_POP,
    ST_CMP_ST,
    ST_CMP_EN,
    ST_CELL,
    ST_PUSH,
    ST_OCT_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic wr_opaque;
    logic rd_flags;
    logic clr_step;
    logic clr_all;
    logic mark_origin;
    logic oct_init;
    logic row_adv;
    logic pop_dec;
    logic pop_load;
    logic dx_inc;
    logic dx_end;
    logic opq_rd;
    logic cell_upd;
    logic push;
    logic oct_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rad_zero;
    logic dx_pos;
    logic row_end;
    logic depth_one;
    logic st_lt_r;
    logic l_lt_en;
    logic need_push;
    logic oct_last;
  } status_t;

  typedef struct packed {
    logic signed [1:0] xx;
    logic signed [1:0] xy;
    logic signed [1:0] yx;
    logic signed [1:0] yy;
  } oct_coef_t;

  function automatic oct_coef_t oct_coef(input logic [2:0] oct);
    oct_coef_t c;
    case (oct)
      3'd0:    c = '{xx: 2'sd1,  xy: 2'sd0,  yx: 2'sd0,  yy: 2'sd1};
      3'd1:    c = '{xx: 2'sd0,  xy: 2'sd1,  yx: 2'sd1,  yy: 2'sd0};
      3'd2:    c = '{xx: 2'sd0,  xy: -2'sd1, yx: 2'sd1,  yy: 2'sd0};
      3'd3:    c = '{xx: -2'sd1, xy: 2'sd0,  yx: 2'sd0,  yy: 2'sd1};
      3'd4:    c = '{xx: -2'sd1, xy: 2'sd0,  yx: 2'sd0,  yy: -2'sd1};
      3'd5:    c = '{xx: 2'sd0,  xy: -2'sd1, yx: -2'sd1, yy: 2'sd0};
      3'd6:    c = '{xx: 2'sd0,  xy: 2'sd1,  yx: -2'sd1, yy: 2'sd0};
      3'd7:    c = '{xx: 2'sd1,  xy: 2'sd0,  yx: 2'sd0,  yy: -2'sd1};
      default: c = '{xx: 2'sd1,  xy: 2'sd0,  yx: 2'sd0,  yy: 2'sd1};
    endcase
    return c;
  endfunction

endpackage

// ===== design/sfov_ctrl.sv =====
// ----------------------------------------------------------------------------
// Shadowcast field of view controller
// State machine that sequences item handling, map clearing and the sweep.
// ----------------------------------------------------------------------------
module sfov_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_opcode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sfov_pkg::status_t sts,
  output sfov_pkg::cmd_t    cmd
);

  sfov_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == sfov_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfov_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfov_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = sfov_pkg::ST_IDLE;
      end
      sfov_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            sfov_pkg::OP_WRITE:   state_nxt = sfov_pkg::ST_WRITE;
            sfov_pkg::OP_READ:    state_nxt = sfov_pkg::ST_READ;
            sfov_pkg::OP_COMPUTE: state_nxt = sfov_pkg::ST_VCLR;
            default:              state_nxt = sfov_pkg::ST_DONE;
          endcase
        end
      end
      sfov_pkg::ST_WRITE:  state_nxt = sfov_pkg::ST_DONE;
      sfov_pkg::ST_READ:   state_nxt = sfov_pkg::ST_DONE;
      sfov_pkg::ST_VCLR: begin
        if (sts.clr_last) state_nxt = sfov_pkg::ST_ORIGIN;
      end
      sfov_pkg::ST_ORIGIN: state_nxt = sfov_pkg::ST_OCT_INIT;
      sfov_pkg::ST_OCT_INIT: begin
        state_nxt = sts.rad_zero ? sfov_pkg::ST_OCT_NEXT : sfov_pkg::ST_ROW;
      end
      sfov_pkg::ST_ROW: begin
        if (sts.dx_pos && sts.row_end) begin
          state_nxt = sts.depth_one ? sfov_pkg::ST_OCT_NEXT : sfov_pkg::ST_POP;
        end else begin
          state_nxt = sfov_pkg::ST_CMP_ST;
        end
      end
      sfov_pkg::ST_POP:    state_nxt = sfov_pkg::ST_ROW;
      sfov_pkg::ST_CMP_ST: begin
        state_nxt = sts.st_lt_r ? sfov_pkg::ST_ROW : sfov_pkg::ST_CMP_EN;
      end
      sfov_pkg::ST_CMP_EN: begin
        state_nxt = sts.l_lt_en ? sfov_pkg::ST_ROW : sfov_pkg::ST_CELL;
      end
      sfov_pkg::ST_CELL: begin
        state_nxt = sts.need_push ? sfov_pkg::ST_PUSH : sfov_pkg::ST_ROW;
      end
      sfov_pkg::ST_PUSH:   state_nxt = sfov_pkg::ST_ROW;
      sfov_pkg::ST_OCT_NEXT: begin
        state_nxt = sts.oct_last ? sfov_pkg::ST_DONE : sfov_pkg::ST_OCT_INIT;
      end
      sfov_pkg::ST_DONE: begin
        if (out_free) state_nxt = sfov_pkg::ST_IDLE;
      end
      default: state_nxt = sfov_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      sfov_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.clr_all  = 1'b1;
      end
      sfov_pkg::ST_IDLE:     cmd.latch_in    = in_valid;
      sfov_pkg::ST_WRITE:    cmd.wr_opaque   = 1'b1;
      sfov_pkg::ST_READ:     cmd.rd_flags    = 1'b1;
      sfov_pkg::ST_VCLR:     cmd.clr_step    = 1'b1;
      sfov_pkg::ST_ORIGIN:   cmd.mark_origin = 1'b1;
      sfov_pkg::ST_OCT_INIT: cmd.oct_init    = 1'b1;
      sfov_pkg::ST_ROW: begin
        if (sts.dx_pos) begin
          cmd.pop_dec = sts.row_end;
          cmd.row_adv = !sts.row_end;
        end
      end
      sfov_pkg::ST_POP:      cmd.pop_load    = 1'b1;
      sfov_pkg::ST_CMP_ST:   cmd.dx_inc      = sts.st_lt_r;
      sfov_pkg::ST_CMP_EN: begin
        cmd.dx_end = sts.l_lt_en;
        cmd.opq_rd = !sts.l_lt_en;
      end
      sfov_pkg::ST_CELL:     cmd.cell_upd    = 1'b1;
      sfov_pkg::ST_PUSH:     cmd.push        = 1'b1;
      sfov_pkg::ST_OCT_NEXT: cmd.oct_next    = 1'b1;
      sfov_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/sfov_dp.sv =====
// ----------------------------------------------------------------------------
// Shadowcast field of view datapath
// Cell maps, scan stack, current frame and slope arithmetic of the sweep.
// ----------------------------------------------------------------------------
module sfov_dp #(
  parameter int GRID_WIDTH  = sfov_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = sfov_pkg::GRID_HEIGHT_DEF,
  parameter int MAX_RADIUS  = sfov_pkg::MAX_RADIUS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfov_pkg::in_item_t in_item,
  output sfov_pkg::out_item_t out_item,
  input  sfov_pkg::cmd_t     cmd,
  output sfov_pkg::status_t  sts
);

  localparam int N_CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int A_W     = $clog2(N_CELLS);
  localparam int R_W     = $clog2(MAX_RADIUS + 1);
  localparam int D_W     = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
  localparam int DX_W    = R_W + 2;
  localparam int S_W     = R_W + 3;
  localparam int C_W     = ((R_W > 8) ? R_W : 8) + 3;
  localparam int F_W     = R_W + DX_W + 6 * S_W + 1;

  localparam logic signed [C_W-1:0] GW_S = C_W'(GRID_WIDTH);
  localparam logic signed [C_W-1:0] GH_S = C_W'(GRID_HEIGHT);

  function automatic logic frac_lt(input logic signed [S_W-1:0] a,
                                   input logic signed [S_W-1:0] b,
                                   input logic signed [S_W-1:0] c,
                                   input logic signed [S_W-1:0] d);
    logic signed [2*S_W-1:0] p;
    logic signed [2*S_W-1:0] q;
    p = a * d;
    q = c * b;
    return p < q;
  endfunction

  function automatic logic signed [C_W-1:0] term(input logic signed [1:0] k,
                                                 input logic signed [C_W-1:0] v);
    logic signed [C_W-1:0] t;
    case (k)
      2'sd1:   t = v;
      -2'sd1:  t = -v;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Item registers.
  logic [1:0]     op_r, op_nxt;
  logic [5:0]     cx_r, cx_nxt, cy_r, cy_nxt;
  logic           opq_in_r, opq_in_nxt;
  logic [R_W-1:0] rad_r, rad_nxt;
  logic [2*R_W-1:0] rad2_r, rad2_nxt;

  // Current (top) frame.
  logic [R_W-1:0]         dist_r, dist_nxt;
  logic signed [DX_W-1:0] dx_r, dx_nxt;
  logic signed [S_W-1:0]  stn_r, stn_nxt, std_r, std_nxt;
  logic signed [S_W-1:0]  enn_r, enn_nxt, end_r, end_nxt;
  logic signed [S_W-1:0]  nsn_r, nsn_nxt, nsd_r, nsd_nxt;
  logic signed [S_W-1:0]  pln_r, pln_nxt, pld_r, pld_nxt;
  logic                   blk_r, blk_nxt;

  logic [R_W-1:0] depth_r, depth_nxt;
  logic [2:0]     oct_r, oct_nxt;
  logic [A_W-1:0] clr_addr_r, clr_addr_nxt;
  sfov_pkg::out_item_t out_r, out_nxt;

  // Memories.
  logic opq_mem [N_CELLS];
  logic vis_mem [N_CELLS];
  logic seen_mem [N_CELLS];
  logic [F_W-1:0] stk_mem [MAX_RADIUS];

  logic opq_rd_r, vis_rd_r, seen_rd_r;
  logic [F_W-1:0] stk_rd_r;

  // Derived values.
  logic            item_in_grid;
  logic [A_W-1:0]  item_addr;
  logic signed [S_W-1:0] dx_s, dist_s, ln, ld, rn, rd;
  logic signed [C_W-1:0] dxc, dyc, mx, my;
  sfov_pkg::oct_coef_t   coef;
  logic            cell_in_grid;
  logic [A_W-1:0]  cell_addr;
  logic            opq_cell;
  logic [R_W:0]    dx_mag;
  logic [2*R_W+1:0] dist_sq;
  logic            in_rad;
  logic            push_ok;
  logic [R_W-1:0]  depth_m1;
  logic [R_W-1:0]  depth_m2;
  logic [F_W-1:0]  frame_cur;
  logic [8:0]      rad_ext;
  logic [8:0]      rad_sat;

  assign item_in_grid = (int'(cx_r) < GRID_WIDTH) && (int'(cy_r) < GRID_HEIGHT);
  assign item_addr    = A_W'(int'(cy_r) * GRID_WIDTH + int'(cx_r));

  assign dx_s   = S_W'(dx_r);
  assign dist_s = $signed(S_W'(dist_r));
  assign ln     = S_W'(1) - (dx_s <<< 1);
  assign ld     = (dist_s <<< 1) - S_W'(1);
  assign rn     = -(dx_s <<< 1) - S_W'(1);
  assign rd     = (dist_s <<< 1) + S_W'(1);

  assign coef = sfov_pkg::oct_coef(oct_r);
  assign dxc  = C_W'(dx_r);
  assign dyc  = -$signed(C_W'(dist_r));
  assign mx   = $signed(C_W'(cx_r)) + term(coef.xx, dxc) + term(coef.xy, dyc);
  assign my   = $signed(C_W'(cy_r)) + term(coef.yx, dxc) + term(coef.yy, dyc);
  assign cell_in_grid = (mx >= 0) && (mx < GW_S) && (my >= 0) && (my < GH_S);
  assign cell_addr    = A_W'(int'(my) * GRID_WIDTH + int'(mx));
  assign opq_cell     = cell_in_grid ? opq_rd_r : 1'b1;

  // The cell step only runs with dx at or below zero.
  assign dx_mag  = (R_W + 1)'(-dx_r);
  assign dist_sq = (2*R_W+2)'(dx_mag) * (2*R_W+2)'(dx_mag)
                 + (2*R_W+2)'(dist_r) * (2*R_W+2)'(dist_r);
  assign in_rad  = dist_sq <= (2*R_W+2)'(rad2_r);

  assign push_ok  = !frac_lt(stn_r, std_r, pln_r, pld_r) && (int'(depth_r) < MAX_RADIUS);
  assign depth_m1 = depth_r - R_W'(1);
  assign depth_m2 = depth_r - R_W'(2);
  assign frame_cur = {dist_r, dx_r, stn_r, std_r, enn_r, end_r, nsn_r, nsd_r, blk_r};

  assign rad_ext = {3'b000, in_item.sight_radius};
  assign rad_sat = (int'(rad_ext) > MAX_RADIUS) ? 9'(MAX_RADIUS) : rad_ext;

  assign sts.clr_last  = (clr_addr_r == A_W'(N_CELLS - 1));
  assign sts.rad_zero  = (rad_r == '0);
  assign sts.dx_pos    = (dx_r > 0);
  assign sts.row_end   = blk_r || (dist_r >= rad_r);
  assign sts.depth_one = (depth_r == R_W'(1));
  assign sts.st_lt_r   = frac_lt(stn_r, std_r, rn, rd);
  assign sts.l_lt_en   = frac_lt(ln, ld, enn_r, end_r);
  assign sts.need_push = !blk_r && opq_cell && (dist_r < rad_r);
  assign sts.oct_last  = (oct_r == 3'd7);

  assign out_item = out_r;

  always_comb begin
    op_nxt = op_r;  cx_nxt = cx_r;  cy_nxt = cy_r;
    opq_in_nxt = opq_in_r;  rad_nxt = rad_r;  rad2_nxt = rad2_r;
    dist_nxt = dist_r;  dx_nxt = dx_r;  blk_nxt = blk_r;
    stn_nxt = stn_r;  std_nxt = std_r;  enn_nxt = enn_r;  end_nxt = end_r;
    nsn_nxt = nsn_r;  nsd_nxt = nsd_r;  pln_nxt = pln_r;  pld_nxt = pld_r;
    depth_nxt = depth_r;  oct_nxt = oct_r;  clr_addr_nxt = clr_addr_r;
    out_nxt = out_r;

    if (cmd.latch_in) begin
      op_nxt     = in_item.opcode;
      cx_nxt     = in_item.cell_x;
      cy_nxt     = in_item.cell_y;
      opq_in_nxt = in_item.opaque;
      rad_nxt    = rad_sat[R_W-1:0];
    end
    if (cmd.clr_step) begin
      clr_addr_nxt = sts.clr_last ? '0 : clr_addr_r + A_W'(1);
    end
    if (cmd.mark_origin) begin
      rad2_nxt = (2*R_W)'(rad_r) * (2*R_W)'(rad_r);
    end
    if (cmd.oct_init) begin
      dist_nxt  = R_W'(1);
      dx_nxt    = -DX_W'(1);
      stn_nxt   = S_W'(1);  std_nxt = S_W'(1);
      enn_nxt   = '0;       end_nxt = S_W'(1);
      nsn_nxt   = '0;       nsd_nxt = S_W'(1);
      blk_nxt   = 1'b0;
      depth_nxt = sts.rad_zero ? '0 : R_W'(1);
    end
    if (cmd.row_adv) begin
      dist_nxt = dist_r + R_W'(1);
      dx_nxt   = DX_W'(0) - DX_W'(dist_r) - DX_W'(1);
    end
    if (cmd.pop_dec) begin
      depth_nxt = depth_m1;
    end
    if (cmd.pop_load) begin
      {dist_nxt, dx_nxt, stn_nxt, std_nxt, enn_nxt, end_nxt, nsn_nxt, nsd_nxt,
       blk_nxt} = stk_rd_r;
    end
    if (cmd.dx_inc) begin
      dx_nxt = dx_r + DX_W'(1);
    end
    if (cmd.dx_end) begin
      dx_nxt = DX_W'(1);
    end
    if (cmd.cell_upd) begin
      dx_nxt = dx_r + DX_W'(1);
      if (blk_r) begin
        if (opq_cell) begin
          nsn_nxt = rn;  nsd_nxt = rd;
        end else begin
          blk_nxt = 1'b0;
          stn_nxt = nsn_r;  std_nxt = nsd_r;
        end
      end else if (opq_cell && (dist_r < rad_r)) begin
        blk_nxt = 1'b1;
        nsn_nxt = rn;  nsd_nxt = rd;
        pln_nxt = ln;  pld_nxt = ld;
      end
    end
    if (cmd.push && push_ok) begin
      // The child row keeps the parent's start slope.
      dist_nxt  = dist_r + R_W'(1);
      dx_nxt    = DX_W'(0) - DX_W'(dist_r) - DX_W'(1);
      enn_nxt   = pln_r;  end_nxt = pld_r;
      nsn_nxt   = '0;     nsd_nxt = S_W'(1);
      blk_nxt   = 1'b0;
      depth_nxt = depth_r + R_W'(1);
    end
    if (cmd.oct_next) begin
      oct_nxt = oct_r + 3'd1;
    end
    if (cmd.out_load) begin
      out_nxt.ack_opcode   = op_r;
      out_nxt.cell_visible = (op_r == sfov_pkg::OP_READ) && item_in_grid && vis_rd_r;
      out_nxt.cell_seen    = (op_r == sfov_pkg::OP_READ) && item_in_grid && seen_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= '0;
      oct_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      depth_r    <= depth_nxt;
      oct_r      <= oct_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  cx_r <= cx_nxt;  cy_r <= cy_nxt;
    opq_in_r <= opq_in_nxt;  rad_r <= rad_nxt;  rad2_r <= rad2_nxt;
    dist_r <= dist_nxt;  dx_r <= dx_nxt;  blk_r <= blk_nxt;
    stn_r <= stn_nxt;  std_r <= std_nxt;  enn_r <= enn_nxt;  end_r <= end_nxt;
    nsn_r <= nsn_nxt;  nsd_r <= nsd_nxt;  pln_r <= pln_nxt;  pld_r <= pld_nxt;
    out_r <= out_nxt;
  end

  // Opaque map.
  always_ff @(posedge clk) begin
    if (cmd.clr_step && cmd.clr_all) begin
      opq_mem[clr_addr_r] <= 1'b0;
    end else if (cmd.wr_opaque && item_in_grid) begin
      opq_mem[item_addr] <= opq_in_r;
    end
    if (cmd.opq_rd) begin
      opq_rd_r <= opq_mem[cell_addr];
    end
  end

  // Visible map.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      vis_mem[clr_addr_r] <= 1'b0;
    end else if (cmd.mark_origin && item_in_grid) begin
      vis_mem[item_addr] <= 1'b1;
    end else if (cmd.cell_upd && in_rad && cell_in_grid) begin
      vis_mem[cell_addr] <= 1'b1;
    end
    if (cmd.rd_flags) begin
      vis_rd_r <= vis_mem[item_addr];
    end
  end

  // Seen map.
  always_ff @(posedge clk) begin
    if (cmd.clr_step && cmd.clr_all) begin
      seen_mem[clr_addr_r] <= 1'b0;
    end else if (cmd.mark_origin && item_in_grid) begin
      seen_mem[item_addr] <= 1'b1;
    end else if (cmd.cell_upd && in_rad && cell_in_grid) begin
      seen_mem[cell_addr] <= 1'b1;
    end
    if (cmd.rd_flags) begin
      seen_rd_r <= seen_mem[item_addr];
    end
  end

  // Scan stack: frames below the top one. The last pop of an octant has no
  // frame below it to fetch.
  always_ff @(posedge clk) begin
    if (cmd.push && push_ok) begin
      stk_mem[depth_m1[D_W-1:0]] <= frame_cur;
    end
    if (cmd.pop_dec && !sts.depth_one) begin
      stk_rd_r <= stk_mem[depth_m2[D_W-1:0]];
    end
  end

endmodule

// ===== design/shadowcast_field_of_view.sv =====
// ----------------------------------------------------------------------------
// Shadowcast field of view
// Grid of cells with opaque, visible and seen flags and a shadowcasting sweep.
// ----------------------------------------------------------------------------
// Usage: each item on the in_ channel carries an opcode. A write stores one
// cell's opaque bit, a read returns one cell's visible and seen flags, and a
// compute clears all visible flags and sweeps the eight octants around an
// origin, marking every cell in sight as visible and seen. Every item gives
// exactly one item on the out_ channel, in order.
// Sequencing: a write or a read passes through its own state before its result
// is loaded into the result register; an unused opcode goes there directly. A
// compute first clears the visible map one cell per cycle, then, for each cell
// the sweep looks at, does one comparison or one map access per cycle, plus the
// octant set-up, octant advance and stack push and pop steps.
// One item is worked on at a time; the next one is accepted once the
// previous result sits in the output register.
// Reset: after rst_n the block clears all three maps one cell per cycle,
// and holds in_ready low meanwhile.
// Stall: a result waits in the output register while out_ready is low; the
// next item may be accepted, and its own result waits until that one leaves.
// ----------------------------------------------------------------------------
module shadowcast_field_of_view #(
  parameter int GRID_WIDTH  = sfov_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = sfov_pkg::GRID_HEIGHT_DEF,
  parameter int MAX_RADIUS  = sfov_pkg::MAX_RADIUS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfov_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sfov_pkg::out_item_t out_data
);

  sfov_pkg::cmd_t    cmd;
  sfov_pkg::status_t sts;

  // The controller decides what happens each cycle from the datapath status.
  sfov_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the maps, the scan stack and the current frame.
  sfov_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .MAX_RADIUS  (MAX_RADIUS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_data),
    .out_item (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== tb/shadowcast_field_of_view_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadowcast field of view testbench
// Drives write, read, compute and unused-opcode items with random gaps on both
// channels, and predicts every result with its own shadowcasting model of the grid.
// ----------------------------------------------------------------------------

// Scoreboard: keeps its own copy of the three cell maps and predicts each
// result when its item is accepted. Results are checked in order.
class view_scoreboard;

  typedef struct {
    int row;
    int dx;
    int st_n;
    int st_d;
    int en_n;
    int en_d;
    int ns_n;
    int ns_d;
    bit blocked;
  } scan_frame_t;

  localparam int GRID_W   = 64;
  localparam int GRID_H   = 64;
  localparam int RAD_MAX  = 63;

  bit                  opaque_map[GRID_W * GRID_H];
  bit                  visible_map[GRID_W * GRID_H];
  bit                  seen_map[GRID_W * GRID_H];
  scan_frame_t         frames[RAD_MAX];
  int                  depth;
  sfov_pkg::out_item_t pending[$];
  int                  errors;

  function bit on_grid(int x, int y);
    return x >= 0 && x < GRID_W && y >= 0 && y < GRID_H;
  endfunction

  function bit blocks_sight(int x, int y);
    if (!on_grid(x, y)) return 1'b1;
    return opaque_map[y * GRID_W + x];
  endfunction

  function void light_cell(int x, int y);
    if (on_grid(x, y)) begin
      visible_map[y * GRID_W + x] = 1'b1;
      seen_map[y * GRID_W + x] = 1'b1;
    end
  endfunction

  // a/b < c/d, both denominators positive.
  function bit slope_lt(int a, int b, int c, int d);
    return a * d < c * b;
  endfunction

  function void push_row(int row, int sn, int sd, int en, int ed, int rad);
    if (row > rad || slope_lt(sn, sd, en, ed) || depth >= RAD_MAX) return;
    frames[depth] = '{row: row, dx: -row, st_n: sn, st_d: sd, en_n: en, en_d: ed,
                      ns_n: 0, ns_d: 1, blocked: 1'b0};
    depth++;
  endfunction

  // One octant of the sweep; recursion is replaced by the frame stack.
  function void sweep_octant(int cx, int cy, int rad, int oct);
    int xx_t[8] = '{1, 0, 0, -1, -1, 0, 0, 1};
    int xy_t[8] = '{0, 1, -1, 0, 0, -1, 1, 0};
    int yx_t[8] = '{0, 1, 1, 0, 0, -1, -1, 0};
    int yy_t[8] = '{1, 0, 0, 1, -1, 0, 0, -1};
    int top, dx, dy, mx, my, ln, ld, rn, rd, sn, sd;
    bit opq;
    depth = 0;
    push_row(1, 1, 1, 0, 1, rad);
    while (depth > 0) begin
      top = depth - 1;
      if (frames[top].dx > 0) begin
        if (frames[top].blocked || frames[top].row >= rad) begin
          depth--;
          continue;
        end
        frames[top].row++;
        frames[top].dx = -frames[top].row;
      end
      dx = frames[top].dx;
      dy = -frames[top].row;
      mx = cx + dx * xx_t[oct] + dy * xy_t[oct];
      my = cy + dx * yx_t[oct] + dy * yy_t[oct];
      ln = 1 - 2 * dx;
      ld = 2 * frames[top].row - 1;
      rn = -2 * dx - 1;
      rd = 2 * frames[top].row + 1;
      if (slope_lt(frames[top].st_n, frames[top].st_d, rn, rd)) begin
        frames[top].dx++;
        continue;
      end
      if (slope_lt(ln, ld, frames[top].en_n, frames[top].en_d)) begin
        frames[top].dx = 1;
        continue;
      end
      if (dx * dx + dy * dy <= rad * rad) light_cell(mx, my);
      opq = blocks_sight(mx, my);
      frames[top].dx++;
      if (frames[top].blocked) begin
        if (opq) begin
          frames[top].ns_n = rn;
          frames[top].ns_d = rd;
        end else begin
          frames[top].blocked = 1'b0;
          frames[top].st_n = frames[top].ns_n;
          frames[top].st_d = frames[top].ns_d;
        end
      end else if (opq && frames[top].row < rad) begin
        sn = frames[top].st_n;
        sd = frames[top].st_d;
        frames[top].blocked = 1'b1;
        frames[top].ns_n = rn;
        frames[top].ns_d = rd;
        push_row(frames[top].row + 1, sn, sd, ln, ld, rad);
      end
    end
  endfunction

  // Called for each accepted input item.
  function void note_item(sfov_pkg::in_item_t it);
    sfov_pkg::out_item_t exp_res;
    int x, y, rad;
    x = it.cell_x;
    y = it.cell_y;
    rad = it.sight_radius;
    exp_res = '{ack_opcode: it.opcode, cell_visible: 1'b0, cell_seen: 1'b0};
    if (it.opcode == sfov_pkg::OP_WRITE) begin
      if (on_grid(x, y)) opaque_map[y * GRID_W + x] = it.opaque;
    end else if (it.opcode == sfov_pkg::OP_COMPUTE) begin
      if (rad > RAD_MAX) rad = RAD_MAX;
      foreach (visible_map[i]) visible_map[i] = 1'b0;
      light_cell(x, y);
      for (int o = 0; o < 8; o++) sweep_octant(x, y, rad, o);
    end else if (it.opcode == sfov_pkg::OP_READ) begin
      if (on_grid(x, y)) begin
        exp_res.cell_visible = visible_map[y * GRID_W + x];
        exp_res.cell_seen = seen_map[y * GRID_W + x];
      end
    end
    pending.push_back(exp_res);
  endfunction

  // Called for each accepted result item.
  function void check_result(sfov_pkg::out_item_t got);
    sfov_pkg::out_item_t want;
    if (pending.size() == 0) begin
      $display("%0t: result with nothing expected: %p", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.ack_opcode !== want.ack_opcode) begin
      $display("%0t: ack_opcode expected %0d actual %0d", $time, want.ack_opcode,
               got.ack_opcode);
      errors++;
    end
    if (got.cell_visible !== want.cell_visible) begin
      $display("%0t: cell_visible expected %0d actual %0d", $time, want.cell_visible,
               got.cell_visible);
      errors++;
    end
    if (got.cell_seen !== want.cell_seen) begin
      $display("%0t: cell_seen expected %0d actual %0d", $time, want.cell_seen,
               got.cell_seen);
      errors++;
    end
  endfunction
endclass

module shadowcast_field_of_view_tb;

  // A large compute clears 4096 cells and then sweeps some thousands of cells,
  // so the quiet limit sits well above that.
  localparam int QUIET_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  sfov_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  sfov_pkg::out_item_t out_data;

  view_scoreboard board;
  int  results_seen;
  int  quiet_cycles;
  bit  stim_done;

  shadowcast_field_of_view dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one item after a random gap, possibly none, and waits for the
  // accept. Valid is only lowered when a gap is actually taken, so a
  // back-to-back item never sees valid dropped and raised in one step.
  task automatic send_item(input sfov_pkg::in_item_t it);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(it);
  endtask

  task automatic send_op(input logic [1:0] op, input int x, input int y,
                         input bit opq, input int rad);
    sfov_pkg::in_item_t it;
    it.opcode = op;
    it.cell_x = x[5:0];
    it.cell_y = y[5:0];
    it.opaque = opq;
    it.sight_radius = rad[5:0];
    send_item(it);
  endtask

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 63) return 63;
    return v;
  endfunction

  // A well-formed scene: scatter walls around an origin, look from it, then
  // read back cells near it. Radii stay small most of the time since a large
  // sweep takes long.
  task automatic send_scene();
    int ox, oy, rad, n;
    ox = $urandom_range(0, 63);
    oy = $urandom_range(0, 63);
    rad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 10);
    n = $urandom_range(2, 6);
    repeat (n) send_op(sfov_pkg::OP_WRITE, clamp_coord(ox + $urandom_range(0, 8) - 4),
                       clamp_coord(oy + $urandom_range(0, 8) - 4),
                       1'($urandom_range(0, 1)), 0);
    send_op(sfov_pkg::OP_COMPUTE, ox, oy, 1'($urandom_range(0, 1)), rad);
    n = $urandom_range(3, 8);
    repeat (n) send_op(sfov_pkg::OP_READ, clamp_coord(ox + $urandom_range(0, 12) - 6),
                       clamp_coord(oy + $urandom_range(0, 12) - 6),
                       1'($urandom_range(0, 1)), $urandom_range(0, 63));
  endtask

  // Stimulus: reset, a directed part, then random scenes mixed with noise.
  initial begin
    sfov_pkg::in_item_t it;
    logic [31:0] rnd;
    int sent;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    stim_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Corners and the edges of every field.
    send_op(sfov_pkg::OP_WRITE, 0, 0, 1'b1, 0);
    send_op(sfov_pkg::OP_WRITE, 63, 63, 1'b1, 63);
    send_op(sfov_pkg::OP_WRITE, 63, 63, 1'b0, 0);
    send_op(sfov_pkg::OP_READ, 0, 0, 1'b0, 0);
    // Radius zero lights only the origin.
    send_op(sfov_pkg::OP_COMPUTE, 63, 0, 1'b0, 0);
    send_op(sfov_pkg::OP_READ, 63, 0, 1'b1, 0);
    send_op(sfov_pkg::OP_READ, 62, 0, 1'b0, 0);
    // A short wall east of an origin, then a small view that casts a shadow.
    send_op(sfov_pkg::OP_WRITE, 12, 10, 1'b1, 0);
    send_op(sfov_pkg::OP_WRITE, 12, 11, 1'b1, 0);
    send_op(sfov_pkg::OP_WRITE, 12, 9, 1'b1, 0);
    send_op(sfov_pkg::OP_COMPUTE, 10, 10, 1'b1, 6);
    send_op(sfov_pkg::OP_READ, 12, 10, 1'b0, 0);
    send_op(sfov_pkg::OP_READ, 14, 10, 1'b0, 0);
    send_op(sfov_pkg::OP_READ, 10, 14, 1'b0, 0);
    // Full radius from a corner, where most neighbors fall off the grid.
    send_op(sfov_pkg::OP_COMPUTE, 0, 63, 1'b0, 63);
    send_op(sfov_pkg::OP_READ, 40, 30, 1'b0, 0);
    // A later view clears visible flags but keeps cells seen.
    send_op(sfov_pkg::OP_COMPUTE, 63, 63, 1'b0, 2);
    send_op(sfov_pkg::OP_READ, 10, 14, 1'b0, 0);
    send_op(sfov_pkg::OP_READ, 62, 62, 1'b0, 0);
    // The unused opcode only echoes back.
    send_op(OP_UNUSED, 33, 21, 1'b1, 42);
    send_op(OP_UNUSED, 0, 0, 1'b0, 0);

    sent = 0;
    while (sent < 80) begin
      if ($urandom_range(0, 3) == 0) begin
        rnd = $urandom;
        it = rnd[$bits(sfov_pkg::in_item_t)-1:0];
        // Keep noise computes cheap except on rare occasions.
        if (it.opcode == sfov_pkg::OP_COMPUTE && $urandom_range(0, 3) != 0)
          it.sight_radius = 6'($urandom_range(0, 6));
        send_item(it);
        sent++;
      end else begin
        send_scene();
        sent += 12;
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, possibly none, plus one long hold-off so the
  // output register fills and the block stops taking input.
  initial begin
    int gap;
    results_seen = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = (results_seen == 30) ? LONG_HOLD : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(out_data);
      results_seen++;
    end
  end

  // Watchdog: ends the run after a long stretch with no accept on either side.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // End of run: all stimulus in, every expected result out, then a short drain
  // to catch any stray result.
  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== shadowcast_field_of_view.f =====
design/sfov_pkg.sv
design/sfov_ctrl.sv
design/sfov_dp.sv
design/shadowcast_field_of_view.sv
tb/shadowcast_field_of_view_tb.sv
